### hdl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, constants and constant tables of the plasma pixel colour core.
// ----------------------------------------------------------------------------
package ppc_pkg;

    typedef longint unsigned t_u64;
    typedef longint          t_s64;

    // Field and table geometry
    localparam int COORD_BITS      = 10;
    localparam int SINE_TABLE_BITS = 10;
    localparam int FRAME_BITS      = 16;
    localparam int TURN_BITS       = 16;
    localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
    localparam int TAB_AW          = SINE_TABLE_BITS + 1;

    // Integer square root geometry: x*x + y*y needs 2*COORD_BITS+1 bits
    localparam int RAD_BITS  = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int SQ_STAGES = (ROOT_BITS + 1) / 2;

    // Phase coefficients, 32-bit turns per unit
    localparam logic [31:0] K_X      = 32'd41013917;
    localparam logic [31:0] K_Y      = 32'd47849569;
    localparam logic [31:0] K_XY     = 32'd27342611;
    localparam logic [31:0] K_R      = 32'd34178264;
    localparam logic [31:0] K_T1     = 32'd34178264;
    localparam logic [31:0] K_T13    = 32'd44431743;
    localparam logic [31:0] K_T07    = 32'd23924785;
    localparam logic [31:0] OFF_2RAD = 32'd1367130551;
    localparam logic [31:0] OFF_4RAD = 32'd2734261102;

    // Sum of four Q1.15 sines, and the bias that moves it to [0, 2^18)
    localparam int          SUM_BITS = 18;
    localparam logic [17:0] SUM_BIAS = 18'd131072;
    localparam int          VP_SHIFT = 13;

    // Request payloads
    typedef struct packed {
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic [FRAME_BITS-1:0] frame_index;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    // Travels alongside the square root pipeline
    typedef struct packed {
        logic [TURN_BITS-1:0] turn_x;
        logic [TURN_BITS-1:0] turn_y;
        logic [TURN_BITS-1:0] turn_xy;
        logic [31:0]          ft1;
    } t_side;

    // Quarter-wave sine table, Q1.15 magnitudes
    typedef logic [15:0] t_qtab [0:QUARTER_LEN];

    localparam t_u64 HALF_PI_Q30 = 64'd1686629713;
    localparam t_u64 SER_DEN [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Taylor series of sin in Q30, six terms past the first
    function automatic logic [15:0] sine_entry(input int unsigned i);
        t_u64 a;
        t_u64 a2;
        t_u64 term;
        t_u64 val;
        t_s64 sum;
        a    = (t_u64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        a2   = (a * a) >> 30;
        term = a;
        sum  = t_s64'(a);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * a2) >> 30) / SER_DEN[k];
            if ((k % 2) == 1) sum = sum - t_s64'(term);
            else              sum = sum + t_s64'(term);
        end
        if (sum < 0) sum = 0;
        val = (t_u64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (val > 64'd32767) val = 64'd32767;
        return val[15:0];
    endfunction

    function automatic t_qtab build_sine_tab();
        t_qtab tab;
        for (int i = 0; i <= QUARTER_LEN; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam t_qtab SINE_TAB = build_sine_tab();

    // Colour bytes per table entry: {byte for negative sine, byte for positive}
    function automatic t_qtab build_chan_tab();
        t_qtab tab;
        int    m;
        int    pos;
        int    neg;
        for (int i = 0; i <= QUARTER_LEN; i++) begin
            m      = int'(SINE_TAB[i]);
            pos    = (127 * m + 128 * 32767) / 32767;
            neg    = (128 * 32767 - 127 * m) / 32767;
            tab[i] = {neg[7:0], pos[7:0]};
        end
        return tab;
    endfunction

    localparam t_qtab CHAN_TAB = build_chan_tab();

    // Table address of a 16-bit turn: mirrored in the odd quadrants
    function automatic logic [TAB_AW-1:0] tab_addr(input logic [TURN_BITS-1:0] turn);
        logic [TAB_AW-1:0] idx;
        idx = {1'b0, turn[13 -: SINE_TABLE_BITS]};
        if (turn[14]) return TAB_AW'(QUARTER_LEN) - idx;
        else          return idx;
    endfunction

endpackage

### hdl/plasma_pixel_color_core.sv
// ----------------------------------------------------------------------------
// plasma_pixel_color_core
// Plasma pattern colour of one pixel: four summed sines mapped to RGB.
//
//   channel  dir  valid        stall        payload
//   in       in   i_in_valid   o_in_stall   i_in_data  (t_pix_in)
//   out      out  o_out_valid  i_out_stall  o_out_data (t_pix_out)
//
// One pixel enters per cycle while o_in_stall is low; each passes the front
// stages, the square root pipeline and the table reads.
// Reset is synchronous and clears only valid bits; no start-up pass.
// A skid register behind the output register holds one result when the
// output stalls; the pipeline freezes only while that skid is full, so
// o_in_stall is a register and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module plasma_pixel_color_core
    import ppc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_pix_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pix_out o_out_data
);

    localparam int TAIL = 8;

    logic en;

    // Front stages
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;
    logic [FRAME_BITS-1:0] r1_f;
    logic                  r1_v;
    logic [31:0]           r2_px;
    logic [31:0]           r2_py;
    logic [31:0]           r2_pxy;
    logic [31:0]           r2_ft1;
    logic [31:0]           r2_ft13;
    logic [31:0]           r2_ft07;
    logic [RAD_BITS-1:0]   r2_xx;
    logic [RAD_BITS-1:0]   r2_yy;
    logic                  r2_v;
    logic [RAD_BITS-1:0]   r3_rad;
    t_side                 r3_side;
    logic                  r3_v;
    logic [31:0]           n3_phx;
    logic [31:0]           n3_phy;
    logic [31:0]           n3_phxy;

    // Square root output
    logic                 sq_v;
    logic [ROOT_BITS-1:0] sq_root;
    t_side                sq_side;

    // Radial phase and sines
    logic [31:0]           rr1_pr;
    t_side                 rr1_side;
    logic [TURN_BITS-1:0]  rr2_tr;
    t_side                 rr2_side;
    logic [31:0]           n_phr;
    logic signed [15:0]    s_x;
    logic signed [15:0]    s_y;
    logic signed [15:0]    s_xy;
    logic signed [15:0]    s_r;
    logic [31:0]           r_vp;
    logic [SUM_BITS-1:0]   n_sum;
    logic [SUM_BITS-1:0]   n_u;
    logic [TURN_BITS-1:0]  r_turn_r;
    logic [TURN_BITS-1:0]  r_turn_g;
    logic [TURN_BITS-1:0]  r_turn_b;
    logic [31:0]           n_phg;
    logic [31:0]           n_phb;
    t_pix_out              c_pix;
    logic                  r_vtail [TAIL];

    // Output register and skid
    t_pix_out r_out;
    logic     r_out_v;
    t_pix_out r_skid;
    logic     r_skid_v;
    logic     take;

    assign en         = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // Stage 1: capture request
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x <= i_in_data.x_coord;
            r1_y <= i_in_data.y_coord;
            r1_f <= i_in_data.frame_index;
        end
    end

    // Stage 2: products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_px   <= 32'(r1_x) * K_X;
            r2_py   <= 32'(r1_y) * K_Y;
            r2_pxy  <= 32'(32'(r1_x) + 32'(r1_y)) * K_XY;
            r2_ft1  <= 32'(r1_f) * K_T1;
            r2_ft13 <= 32'(r1_f) * K_T13;
            r2_ft07 <= 32'(r1_f) * K_T07;
            r2_xx   <= RAD_BITS'(r1_x) * RAD_BITS'(r1_x);
            r2_yy   <= RAD_BITS'(r1_y) * RAD_BITS'(r1_y);
        end
    end

    // Stage 3: phases and radicand
    assign n3_phx  = r2_px + r2_ft1;
    assign n3_phy  = r2_py + r2_ft13;
    assign n3_phxy = r2_pxy + r2_ft07;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad          <= r2_xx + r2_yy;
            r3_side.turn_x  <= n3_phx[31:16];
            r3_side.turn_y  <= n3_phy[31:16];
            r3_side.turn_xy <= n3_phxy[31:16];
            r3_side.ft1     <= r2_ft1;
        end
    end

    // Radial distance
    ppc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r3_v),
        .i_radicand (r3_rad),
        .i_side     (r3_side),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // Radial phase: product, then time term
    assign n_phr = rr1_pr + rr1_side.ft1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rr1_pr   <= 32'(sq_root) * K_R;
            rr1_side <= sq_side;
            rr2_tr   <= n_phr[31:16];
            rr2_side <= rr1_side;
        end
    end

    // Four sines
    ppc_sine u_sine_x  (.i_clk(i_clk), .i_en(en), .i_turn(rr2_side.turn_x),  .o_sine(s_x));
    ppc_sine u_sine_y  (.i_clk(i_clk), .i_en(en), .i_turn(rr2_side.turn_y),  .o_sine(s_y));
    ppc_sine u_sine_xy (.i_clk(i_clk), .i_en(en), .i_turn(rr2_side.turn_xy), .o_sine(s_xy));
    ppc_sine u_sine_r  (.i_clk(i_clk), .i_en(en), .i_turn(rr2_tr),           .o_sine(s_r));

    // Sum, biased to unsigned, placed as a 32-bit phase
    assign n_sum = {{2{s_x[15]}}, s_x} + {{2{s_y[15]}}, s_y}
                 + {{2{s_xy[15]}}, s_xy} + {{2{s_r[15]}}, s_r};
    assign n_u   = n_sum + SUM_BIAS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vp <= {1'b0, n_u, {VP_SHIFT{1'b0}}};
        end
    end

    // Colour phase offsets
    assign n_phg = r_vp + OFF_2RAD;
    assign n_phb = r_vp + OFF_4RAD;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_turn_r <= r_vp[31:16];
            r_turn_g <= n_phg[31:16];
            r_turn_b <= n_phb[31:16];
        end
    end

    ppc_chan u_chan_r (.i_clk(i_clk), .i_en(en), .i_turn(r_turn_r), .o_byte(c_pix.red));
    ppc_chan u_chan_g (.i_clk(i_clk), .i_en(en), .i_turn(r_turn_g), .o_byte(c_pix.green));
    ppc_chan u_chan_b (.i_clk(i_clk), .i_en(en), .i_turn(r_turn_b), .o_byte(c_pix.blue));

    // Valid bits of the front and tail stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int k = 0; k < TAIL; k++) r_vtail[k] <= 1'b0;
        end else if (en) begin
            r1_v       <= i_in_valid;
            r2_v       <= r1_v;
            r3_v       <= r2_v;
            r_vtail[0] <= sq_v;
            for (int k = 1; k < TAIL; k++) r_vtail[k] <= r_vtail[k-1];
        end
    end

    // Output register with skid
    assign take = r_out_v && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_vtail[TAIL-1]) begin
            if (!r_out_v || take) begin
                r_out   <= c_pix;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= c_pix;
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### hdl/ppc_isqrt.sv
// ----------------------------------------------------------------------------
// ppc_isqrt
// Pipelined floor square root, two result bits per stage, with sideband.
// ----------------------------------------------------------------------------
module ppc_isqrt
    import ppc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_BITS-1:0]  i_radicand,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [ROOT_BITS-1:0] o_root,
    output t_side                o_side
);

    localparam int WB = RAD_BITS + 1;

    typedef struct packed {
        logic [WB-1:0] rem;
        logic [WB-1:0] root;
    } t_sq;

    t_sq   r_st   [SQ_STAGES];
    t_sq   n_st   [SQ_STAGES];
    t_side r_side [SQ_STAGES];
    logic  r_v    [SQ_STAGES];

    // One compare-and-subtract step; steps past the last root bit pass through
    function automatic t_sq sqrt_step(input t_sq s, input int j);
        t_sq           o;
        logic [WB-1:0] bit_w;
        logic [WB-1:0] trial;
        o = s;
        if (j < ROOT_BITS) begin
            bit_w = WB'(1) << (2 * (ROOT_BITS - 1 - j));
            trial = s.root + bit_w;
            if (s.rem >= trial) begin
                o.rem  = s.rem - trial;
                o.root = (s.root >> 1) + bit_w;
            end else begin
                o.root = s.root >> 1;
            end
        end
        return o;
    endfunction

    // Next value of every stage
    always_comb begin
        t_sq init;
        init.rem  = WB'(i_radicand);
        init.root = '0;
        n_st[0]   = sqrt_step(sqrt_step(init, 0), 1);
        for (int g = 1; g < SQ_STAGES; g++) begin
            n_st[g] = sqrt_step(sqrt_step(r_st[g-1], 2 * g), 2 * g + 1);
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]   <= n_st[0];
            r_side[0] <= i_side;
            for (int g = 1; g < SQ_STAGES; g++) begin
                r_st[g]   <= n_st[g];
                r_side[g] <= r_side[g-1];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < SQ_STAGES; g++) r_v[g] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int g = 1; g < SQ_STAGES; g++) r_v[g] <= r_v[g-1];
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_st[SQ_STAGES-1].root[ROOT_BITS-1:0];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

### hdl/ppc_sine.sv
// ----------------------------------------------------------------------------
// ppc_sine
// Q1.15 sine of a 16-bit turn: registered table read, then sign.
// ----------------------------------------------------------------------------
module ppc_sine
    import ppc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [TURN_BITS-1:0] i_turn,
    output logic signed [15:0]   o_sine
);

    logic [15:0] r_mag;
    logic        r_neg;

    // Table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= SINE_TAB[tab_addr(i_turn)];
            r_neg <= i_turn[15];
        end
    end

    // Lower half-wave is negative
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sine <= r_neg ? 16'(16'd0 - r_mag) : r_mag;
        end
    end

endmodule

### hdl/ppc_chan.sv
// ----------------------------------------------------------------------------
// ppc_chan
// Colour byte 128 + 127*sin of a 16-bit turn, from a byte table.
// ----------------------------------------------------------------------------
module ppc_chan
    import ppc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [TURN_BITS-1:0] i_turn,
    output logic [7:0]           o_byte
);

    logic [15:0] r_ent;
    logic        r_neg;

    // Table read: both bytes of the entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ent <= CHAN_TAB[tab_addr(i_turn)];
            r_neg <= i_turn[15];
        end
    end

    // Pick the byte for the sign of the sine
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_byte <= r_neg ? r_ent[15:8] : r_ent[7:0];
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for plasma_pixel_color_core: pixel requests go in
// through the valid/stall port and each colour result is compared, channel by
// channel, with an independent bit-exact prediction of the plasma sine sum.
// Directed corners come first, then raster runs and scattered pixels under
// four idling patterns, with a full drain between patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    // Colour predictor and store of expected colours, oldest first
    class plasma_colour_scoreboard;
        // Phase steps in 32-bit turns per unit
        localparam bit [31:0] PH_X    = 32'd41013917;
        localparam bit [31:0] PH_Y    = 32'd47849569;
        localparam bit [31:0] PH_XY   = 32'd27342611;
        localparam bit [31:0] PH_R    = 32'd34178264;
        localparam bit [31:0] PH_T1   = 32'd34178264;
        localparam bit [31:0] PH_T13  = 32'd44431743;
        localparam bit [31:0] PH_T07  = 32'd23924785;
        localparam bit [31:0] PH_2RAD = 32'd1367130551;
        localparam bit [31:0] PH_4RAD = 32'd2734261102;

        int       quarter_sine [0:QUARTER_LEN];
        t_pix_out colour_queue [$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
            for (int i = 0; i <= QUARTER_LEN; i++) begin
                quarter_sine[i] = taylor_sine(i);
            end
        endfunction

        // Q1.15 magnitude of sin(i * pi / (2 * QUARTER_LEN)), series in Q30
        function int taylor_sine(int unsigned i);
            longint unsigned a;
            longint unsigned a2;
            longint unsigned term;
            longint unsigned den;
            longint unsigned val;
            longint          acc;
            a    = (64'(i) * 64'd1686629713) >> SINE_TABLE_BITS;
            a2   = (a * a) >> 30;
            term = a;
            acc  = longint'(a);
            for (int k = 1; k <= 6; k++) begin
                den  = 64'((2 * k) * (2 * k + 1));
                term = ((term * a2) >> 30) / den;
                if (k % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            val = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (val > 64'd32767) val = 64'd32767;
            return int'(val);
        endfunction

        // Table sine of a 32-bit phase, no interpolation
        function int sine_of(bit [31:0] phase);
            bit [15:0] turn;
            int        idx;
            int        mag;
            turn = phase[31:16];
            idx  = int'(turn[13:0] >> (14 - SINE_TABLE_BITS));
            mag  = turn[14] ? quarter_sine[QUARTER_LEN - idx] : quarter_sine[idx];
            return turn[15] ? -mag : mag;
        endfunction

        // Floor square root, bit by bit
        function bit [31:0] root_of(bit [31:0] n);
            bit [31:0] root;
            bit [31:0] probe;
            root  = 0;
            probe = 32'd1 << 30;
            while (probe > n) probe = probe >> 2;
            while (probe != 0) begin
                if (n >= root + probe) begin
                    n    = n - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function bit [7:0] channel_of(bit [31:0] phase);
            longint num;
            longint c;
            num = longint'(sine_of(phase)) * 127 + 128 * 32767;
            if (num < 0) num = 0;
            c = num / 32767;
            if (c < 1)   c = 1;
            if (c > 255) c = 255;
            return c[7:0];
        endfunction

        function t_pix_out predict_colour(t_pix_in px);
            bit [31:0] x;
            bit [31:0] y;
            bit [31:0] f;
            bit [31:0] r;
            bit [31:0] vphase;
            int        total;
            t_pix_out  colour;
            x = 32'(px.x_coord);
            y = 32'(px.y_coord);
            f = 32'(px.frame_index);
            r = root_of(x * x + y * y);
            total = sine_of(x * PH_X + f * PH_T1)
                  + sine_of(y * PH_Y + f * PH_T13)
                  + sine_of((x + y) * PH_XY + f * PH_T07)
                  + sine_of(r * PH_R + f * PH_T1);
            vphase = 32'(total + 131072);
            vphase = vphase << 13;
            colour.red   = channel_of(vphase);
            colour.green = channel_of(vphase + PH_2RAD);
            colour.blue  = channel_of(vphase + PH_4RAD);
            return colour;
        endfunction

        function void note_pixel(t_pix_in px);
            colour_queue.push_back(predict_colour(px));
        endfunction

        function void check_colour(t_pix_out got);
            t_pix_out want;
            if (colour_queue.size() == 0) begin
                $error("unexpected colour r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
                mismatch_count++;
                return;
            end
            want = colour_queue.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                mismatch_count++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                mismatch_count++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return colour_queue.size();
        endfunction

        function void flag_leftovers();
            if (colour_queue.size() != 0) begin
                $error("%0d expected colours never arrived", colour_queue.size());
                mismatch_count++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_pix_in  in_data   = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_pix_out o_out_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    plasma_colour_scoreboard sb;

    plasma_pixel_color_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: check on acceptance, then choose the next stall
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            sb.check_colour(o_out_data);
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // One request: optional idle gap, then hold while the core stalls
    task automatic push_pixel(input t_pix_in px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    task automatic push_xyf(input int x, input int y, input int f);
        t_pix_in px;
        px.x_coord     = x[COORD_BITS-1:0];
        px.y_coord     = y[COORD_BITS-1:0];
        px.frame_index = f[FRAME_BITS-1:0];
        push_pixel(px);
    endtask

    // Hold off new requests until every colour is back
    task automatic drain_colours();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Raster runs along a row at a fixed frame, mixed with scattered pixels
    task automatic push_random_pixels(input int count);
        int                    sent;
        int                    run_len;
        logic [COORD_BITS-1:0] x0;
        t_pix_in               px;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(1) == 1) begin
                run_len        = $urandom_range(4, 16);
                x0             = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
                px.y_coord     = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
                px.frame_index = FRAME_BITS'($urandom_range(65535));
                for (int j = 0; j < run_len && sent < count; j++) begin
                    px.x_coord = x0 + COORD_BITS'(j);
                    push_pixel(px);
                    sent++;
                end
            end else begin
                px.x_coord     = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
                px.y_coord     = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
                px.frame_index = FRAME_BITS'($urandom_range(65535));
                push_pixel(px);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners: origin, far corner, edges, frame wrap, alternating bits
        push_xyf(0, 0, 0);
        push_xyf(1023, 1023, 65535);
        push_xyf(1023, 0, 0);
        push_xyf(0, 1023, 0);
        push_xyf(1023, 1023, 0);
        push_xyf(0, 0, 65535);
        push_xyf(0, 0, 0);
        push_xyf(1, 1, 1);
        push_xyf(512, 512, 32768);
        push_xyf(723, 724, 100);
        push_xyf(341, 682, 21845);
        push_xyf(682, 341, 43690);
        push_xyf(1023, 1, 65534);
        push_xyf(1, 1023, 1);
        push_xyf(100, 200, 126);
        push_xyf(511, 511, 32767);
        drain_colours();

        // Idling patterns: none, sender only, receiver only, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            push_random_pixels(100);
            drain_colours();
        end

        stall_pct = 0;
        repeat (40) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### plasma_pixel_color_core.f
hdl/ppc_pkg.sv
hdl/ppc_isqrt.sv
hdl/ppc_sine.sv
hdl/ppc_chan.sv
hdl/plasma_pixel_color_core.sv
sim/tb_top.sv
